FILE: hw/rtl/rmq_pkg.sv
// Shared widths, codes and helpers for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // signed trace / root argument
  localparam int ARG_W     = DATA_WIDTH + 3;
  // radicand, rounded down to an even width
  localparam int SQ_IN_W   = ((DATA_WIDTH + FRAC_BITS + 3) / 2) * 2;
  localparam int ROOT_W    = SQ_IN_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 2;
  // signed off-diagonal sum or difference
  localparam int S_W       = DATA_WIDTH + 1;
  // dividend (mag << FRAC_BITS) + root
  localparam int NUM_W     = DATA_WIDTH + 2 + FRAC_BITS;
  // root >= 2^(FRAC_BITS/2), so the quotient fits in Q_W bits
  localparam int Q_W       = NUM_W - FRAC_BITS / 2 - 1;
  localparam int DIV_REM_W = ROOT_W + 2;

  localparam logic [ARG_W-1:0] ONE_Q =
    {{(ARG_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // branch codes; also the quaternion slot that holds the diagonal term
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef struct packed {
    logic [3:0][S_W-1:0] s;       // per slot w,x,y,z
    logic [1:0]          branch;
    logic                invalid;
  } side_t;

  // saturate a sign/magnitude quotient to the signed output range
  function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic [Q_W-1:0] q,
                                                    input logic neg);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] nq;
    lim = {{(Q_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    nq  = ~q + 1'b1;
    if (!neg) begin
      if (q > lim) return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
      return q[DATA_WIDTH-1:0];
    end
    if (q > lim + 1'b1) return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    return nq[DATA_WIDTH-1:0];
  endfunction

endpackage

FILE: hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, side data carried along.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rmq_pkg::SQ_IN_W-1:0]  in_rad,
  input  rmq_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [rmq_pkg::ROOT_W-1:0]   out_root,
  output rmq_pkg::side_t               out_side
);

  logic                          v    [rmq_pkg::ROOT_W+1];
  logic [rmq_pkg::SQ_IN_W-1:0]   rad  [rmq_pkg::ROOT_W+1];
  logic [rmq_pkg::SQ_REM_W-1:0]  rem  [rmq_pkg::ROOT_W+1];
  logic [rmq_pkg::ROOT_W-1:0]    root [rmq_pkg::ROOT_W+1];
  rmq_pkg::side_t                side [rmq_pkg::ROOT_W+1];

  assign v[0]    = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar g = 0; g < rmq_pkg::ROOT_W; g++) begin : g_stage
    logic [rmq_pkg::SQ_REM_W-1:0] rsh;
    logic [rmq_pkg::SQ_REM_W-1:0] trial;
    logic                         ge;

    always_comb begin
      // bring down the next two radicand bits
      rsh   = {rem[g][rmq_pkg::SQ_REM_W-3:0], rad[g][rmq_pkg::SQ_IN_W-1 -: 2]};
      trial = {root[g], 2'b01};
      ge    = rsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) v[g+1] <= 1'b0;
      else v[g+1] <= v[g];
    end

    always_ff @(posedge clk) begin
      rad[g+1]  <= rad[g] << 2;
      rem[g+1]  <= ge ? rsh - trial : rsh;
      root[g+1] <= {root[g][rmq_pkg::ROOT_W-2:0], ge};
      side[g+1] <= side[g];
    end
  end

  assign out_valid = v[rmq_pkg::ROOT_W];
  assign out_root  = root[rmq_pkg::ROOT_W];
  assign out_side  = side[rmq_pkg::ROOT_W];

endmodule

FILE: hw/rtl/rmq_div.sv
// Four-lane pipelined restoring divider: round(s * 2^F / (2*root)), sign/magnitude.
// Also forms the rounded half root. Depends on rmq_pkg.
module rmq_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rmq_pkg::ROOT_W-1:0]   in_root,
  input  rmq_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [3:0][rmq_pkg::Q_W-1:0] out_q,
  output logic [3:0]                   out_neg,
  output logic [rmq_pkg::ROOT_W-1:0]   out_half,
  output rmq_pkg::side_t               out_side
);

  localparam int HI_W = rmq_pkg::NUM_W - rmq_pkg::Q_W;

  logic                                  v    [rmq_pkg::Q_W+1];
  logic [3:0][rmq_pkg::Q_W-1:0]          lo   [rmq_pkg::Q_W+1];
  logic [3:0][rmq_pkg::DIV_REM_W-1:0]    rem  [rmq_pkg::Q_W+1];
  logic [3:0][rmq_pkg::Q_W-1:0]          quo  [rmq_pkg::Q_W+1];
  logic [rmq_pkg::DIV_REM_W-1:0]         dvs  [rmq_pkg::Q_W+1];
  logic [3:0]                            neg  [rmq_pkg::Q_W+1];
  logic [rmq_pkg::ROOT_W-1:0]            half [rmq_pkg::Q_W+1];
  rmq_pkg::side_t                        side [rmq_pkg::Q_W+1];

  logic [3:0][rmq_pkg::S_W-1:0]   mag;
  logic [3:0][rmq_pkg::NUM_W-1:0] num;
  logic [3:0]                     sgn;
  logic [rmq_pkg::ROOT_W:0]       rp1;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sgn[l] = in_side.s[l][rmq_pkg::S_W-1];
      // magnitude at the sum width, so -2^(S_W-1) comes out as 2^(S_W-1)
      mag[l] = sgn[l] ? ~in_side.s[l] + 1'b1 : in_side.s[l];
      num[l] = (rmq_pkg::NUM_W'(mag[l]) << rmq_pkg::FRAC_BITS)
               + rmq_pkg::NUM_W'(in_root);
    end
    rp1 = {1'b0, in_root} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      lo[0][l]  <= num[l][rmq_pkg::Q_W-1:0];
      rem[0][l] <= rmq_pkg::DIV_REM_W'(num[l][rmq_pkg::NUM_W-1 -: HI_W]);
      quo[0][l] <= '0;
    end
    dvs[0]  <= rmq_pkg::DIV_REM_W'({in_root, 1'b0});
    neg[0]  <= sgn;
    half[0] <= rp1[rmq_pkg::ROOT_W:1];
    side[0] <= in_side;
  end

  for (genvar g = 0; g < rmq_pkg::Q_W; g++) begin : g_stage
    logic [3:0][rmq_pkg::DIV_REM_W-1:0] rsh;
    logic [3:0]                         ge;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rsh[l] = {rem[g][l][rmq_pkg::DIV_REM_W-2:0], lo[g][l][rmq_pkg::Q_W-1]};
        ge[l]  = rsh[l] >= dvs[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v[g+1] <= 1'b0;
      else v[g+1] <= v[g];
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 4; l++) begin
        rem[g+1][l] <= ge[l] ? rsh[l] - dvs[g] : rsh[l];
        lo[g+1][l]  <= lo[g][l] << 1;
        quo[g+1][l] <= {quo[g][l][rmq_pkg::Q_W-2:0], ge[l]};
      end
      dvs[g+1]  <= dvs[g];
      neg[g+1]  <= neg[g];
      half[g+1] <= half[g];
      side[g+1] <= side[g];
    end
  end

  assign out_valid = v[rmq_pkg::Q_W];
  assign out_q     = quo[rmq_pkg::Q_W];
  assign out_neg   = neg[rmq_pkg::Q_W];
  assign out_half  = half[rmq_pkg::Q_W];
  assign out_side  = side[rmq_pkg::Q_W];

endmodule

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix (Q2.14) to quaternion converter, fully pipelined.
// Depends on rmq_pkg, rmq_sqrt, rmq_div.
//
//   channel  | handshake      | payload
//   ---------+----------------+--------------------------------------------
//   request  | start / busy   | m00 m01 m02 m10 m11 m12 m20 m21 m22
//   result   | done (1 cycle) | qw qx qy qz branch invalid
//
// One request per cycle; busy stays low. The pipeline holds one setup stage,
// one stage per root bit in the square root, one setup stage plus one stage
// per quotient bit in the divider, and one output stage.
// Synchronous reset empties the pipeline. The receiver cannot stall, so done
// is a one-cycle strobe and nothing is held back.
module rotation_matrix_to_quaternion (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m00,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m01,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m02,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m10,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m11,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m12,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m20,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m21,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0]   m22,
  output logic                                    done,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0]   qw,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0]   qx,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0]   qy,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0]   qz,
  output logic [1:0]                              branch,
  output logic                                    invalid
);

  localparam int AW = rmq_pkg::ARG_W;
  localparam int SW = rmq_pkg::S_W;

  assign busy = 1'b0;

  // setup stage
  logic signed [AW-1:0]          trace, arg, argf;
  logic signed [AW-1:0]          dii, djj, dkk;
  logic                          tpos, bad;
  logic [1:0]                    sel;
  rmq_pkg::side_t                side_d;
  logic [rmq_pkg::SQ_IN_W-1:0]   rad_d;

  always_comb begin
    trace = AW'(m00) + AW'(m11) + AW'(m22);
    tpos  = trace > 0;
    // largest diagonal, lower index wins ties
    sel = rmq_pkg::BR_X;
    dii = AW'(m00);
    if (m11 > m00) begin
      sel = rmq_pkg::BR_Y;
      dii = AW'(m11);
    end
    if (AW'(m22) > dii) begin
      sel = rmq_pkg::BR_Z;
      dii = AW'(m22);
    end
    side_d.s = '0;
    case (sel)
      rmq_pkg::BR_X: begin
        djj = AW'(m11);
        dkk = AW'(m22);
        side_d.s[0] = SW'(m21) - SW'(m12);
        side_d.s[2] = SW'(m10) + SW'(m01);
        side_d.s[3] = SW'(m20) + SW'(m02);
      end
      rmq_pkg::BR_Y: begin
        djj = AW'(m22);
        dkk = AW'(m00);
        side_d.s[0] = SW'(m02) - SW'(m20);
        side_d.s[1] = SW'(m01) + SW'(m10);
        side_d.s[3] = SW'(m21) + SW'(m12);
      end
      default: begin
        djj = AW'(m00);
        dkk = AW'(m11);
        side_d.s[0] = SW'(m10) - SW'(m01);
        side_d.s[1] = SW'(m02) + SW'(m20);
        side_d.s[2] = SW'(m12) + SW'(m21);
      end
    endcase
    arg = dii - djj - dkk + $signed(rmq_pkg::ONE_Q);
    if (tpos) begin
      side_d.s    = '0;
      side_d.s[1] = SW'(m21) - SW'(m12);
      side_d.s[2] = SW'(m02) - SW'(m20);
      side_d.s[3] = SW'(m10) - SW'(m01);
      argf = trace + $signed(rmq_pkg::ONE_Q);
    end else begin
      argf = arg;
    end
    bad            = !tpos && (argf <= 0);
    side_d.branch  = tpos ? rmq_pkg::BR_TRACE : sel;
    side_d.invalid = bad;
    rad_d = bad ? '0
                : rmq_pkg::SQ_IN_W'($unsigned(argf)) << rmq_pkg::FRAC_BITS;
  end

  logic                          v1;
  logic [rmq_pkg::SQ_IN_W-1:0]   rad1;
  rmq_pkg::side_t                side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    rad1  <= rad_d;
    side1 <= side_d;
  end

  logic                          sq_v;
  logic [rmq_pkg::ROOT_W-1:0]    sq_root;
  rmq_pkg::side_t                sq_side;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_rad    (rad1),
    .in_side   (side1),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic                            dv_v;
  logic [3:0][rmq_pkg::Q_W-1:0]    dv_q;
  logic [3:0]                      dv_neg;
  logic [rmq_pkg::ROOT_W-1:0]      dv_half;
  rmq_pkg::side_t                  dv_side;

  rmq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_v),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_neg   (dv_neg),
    .out_half  (dv_half),
    .out_side  (dv_side)
  );

  // output stage: pick diagonal term, saturate, zero on invalid
  logic [3:0][rmq_pkg::DATA_WIDTH-1:0] comp;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (dv_side.invalid) comp[l] = '0;
      else if (dv_side.branch == 2'(l))
        comp[l] = rmq_pkg::sat_mag(rmq_pkg::Q_W'(dv_half), 1'b0);
      else comp[l] = rmq_pkg::sat_mag(dv_q[l], dv_neg[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_v;
  end

  always_ff @(posedge clk) begin
    qw      <= comp[0];
    qx      <= comp[1];
    qy      <= comp[2];
    qz      <= comp[3];
    branch  <= dv_side.branch;
    invalid <= dv_side.invalid;
  end

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    done && invalid |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
    else $error("invalid result with nonzero components");

  a_inv_branch: assert property (@(posedge clk) disable iff (rst)
    done && invalid |-> branch != rmq_pkg::BR_TRACE)
    else $error("invalid flagged on positive trace");

  a_w_nonneg: assert property (@(posedge clk) disable iff (rst)
    done && !invalid && branch == rmq_pkg::BR_TRACE |-> !qw[rmq_pkg::DATA_WIDTH-1])
    else $error("negative w on positive trace");

endmodule

FILE: tb/sv/rotation_matrix_to_quaternion_tb.sv
// Self-checking testbench for rotation_matrix_to_quaternion.
// Depends on rmq_pkg and the block; drives directed and random matrices, checks each result.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

  localparam int DW = rmq_pkg::DATA_WIDTH;
  localparam int FB = rmq_pkg::FRAC_BITS;
  localparam int N_RAND = 500;
  localparam int LATENCY = 3 + rmq_pkg::ROOT_W + rmq_pkg::Q_W;
  localparam longint CYCLE_LIMIT = 200000;

  typedef logic signed [DW-1:0] elem_t;

  typedef struct packed {
    elem_t w, x, y, z;
    logic [1:0] br;
    logic inv;
  } quat_t;

  typedef struct {
    elem_t m [9];
    logic known;   // expected result typed in
    quat_t q;
  } row_t;

  logic clk = 0, rst = 1, start = 0;
  elem_t m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0, m20 = 0, m21 = 0, m22 = 0;
  logic busy, done, invalid;
  logic [1:0] branch;
  elem_t qw, qx, qy, qz;

  rotation_matrix_to_quaternion u_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  quat_t pending_quats[$];
  int errors = 0;
  longint cycles = 0;

  function automatic longint clamp(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (DW - 1)) - 1;
    lo = -(64'sd1 <<< (DW - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint scaled_ratio(longint s, longint root);
    longint mag, q;
    mag = s < 0 ? -s : s;
    q = ((mag <<< FB) + root) / (2 * root);
    return clamp(s < 0 ? -q : q);
  endfunction

  function automatic quat_t matrix_to_quat(elem_t e [9]);
    longint m [3][3];
    longint q [4];
    longint tr, arg, root;
    int i, j, k;
    quat_t r;
    for (int a = 0; a < 9; a++) m[a / 3][a % 3] = e[a];
    q = '{0, 0, 0, 0};
    r.inv = 0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      root = int_sqrt((tr + (64'sd1 <<< FB)) <<< FB);
      r.br = rmq_pkg::BR_TRACE;
      q[0] = clamp((root + 1) >>> 1);
      q[1] = scaled_ratio(m[2][1] - m[1][2], root);
      q[2] = scaled_ratio(m[0][2] - m[2][0], root);
      q[3] = scaled_ratio(m[1][0] - m[0][1], root);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      r.br = 2'(i + 1);
      arg = m[i][i] - m[j][j] - m[k][k] + (64'sd1 <<< FB);
      if (arg <= 0) r.inv = 1;
      else begin
        root = int_sqrt(arg <<< FB);
        q[1 + i] = clamp((root + 1) >>> 1);
        q[0] = scaled_ratio(m[k][j] - m[j][k], root);
        q[1 + j] = scaled_ratio(m[j][i] + m[i][j], root);
        q[1 + k] = scaled_ratio(m[k][i] + m[i][k], root);
      end
    end
    r.w = elem_t'(q[0]);
    r.x = elem_t'(q[1]);
    r.y = elem_t'(q[2]);
    r.z = elem_t'(q[3]);
    return r;
  endfunction

  function automatic row_t mk(elem_t a0, elem_t a1, elem_t a2, elem_t a3, elem_t a4,
                              elem_t a5, elem_t a6, elem_t a7, elem_t a8);
    row_t r;
    r.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    r.known = 0;
    return r;
  endfunction

  function automatic row_t mk_q(row_t r, elem_t w, elem_t x, elem_t y, elem_t z,
                                logic [1:0] br, logic inv);
    r.known = 1;
    r.q = '{w, x, y, z, br, inv};
    return r;
  endfunction

  localparam elem_t ONE = elem_t'(1 << FB);
  localparam elem_t MAXV = elem_t'((1 << (DW - 1)) - 1);
  localparam elem_t MINV = elem_t'(-(1 << (DW - 1)));

  row_t stim_table[$];

  task automatic build_table();
    // identity: trace 3, root 2.0, w = 1.0
    stim_table.push_back(mk_q(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
                              ONE, 0, 0, 0, rmq_pkg::BR_TRACE, 0));
    // all zero: x branch, root 1.0, x = 0.5
    stim_table.push_back(mk_q(mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
                              0, ONE / 2, 0, 0, rmq_pkg::BR_X, 0));
    // all minimum, all maximum, alternating maximum and minimum
    stim_table.push_back(mk(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    stim_table.push_back(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    stim_table.push_back(mk(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV));
    // 180 degree turns about each axis
    stim_table.push_back(mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    stim_table.push_back(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    stim_table.push_back(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    // ties among diagonals
    stim_table.push_back(mk(-ONE, 5, -7, 9, -ONE, 11, -13, 15, -ONE));
    stim_table.push_back(mk(-ONE, 5, -7, 9, 0, 11, -13, 15, 0));
    stim_table.push_back(mk(-ONE, 0, 0, 0, -ONE/2, 0, 0, 0, -ONE/2));
    // trace exactly zero and one lsb
    stim_table.push_back(mk(1, 3, 4, -3, 0, 2, -4, -2, -1));
    stim_table.push_back(mk(1, 3, 4, -3, 0, 2, -4, -2, 0));
    // small root, saturating off-diagonal terms
    stim_table.push_back(mk(MINV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MINV, MAXV));
    stim_table.push_back(mk(MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV + 1));
    stim_table.push_back(mk(1, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0));
    // 90 degree turns
    stim_table.push_back(mk(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
    stim_table.push_back(mk(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0));
    stim_table.push_back(mk(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0));
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'($urandom);
      1: return $urandom_range(0, 1) ? MAXV : MINV;
      2: return elem_t'($urandom_range(0, 2 * ONE) - ONE);
      3: return elem_t'($urandom_range(0, 64) - 32);
      default: return elem_t'($urandom_range(0, 2 * ONE) - ONE);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int pick;
    for (int a = 0; a < 9; a++) r.m[a] = rand_elem();
    pick = $urandom_range(0, 3);
    // steer diagonals so every branch is common
    if (pick > 0) begin
      for (int d = 0; d < 3; d++) r.m[4 * d] = elem_t'(-$urandom_range(0, ONE));
      r.m[4 * (pick - 1)] = elem_t'($urandom_range(0, ONE));
    end
    r.known = 0;
    return r;
  endfunction

  task automatic send_request(row_t r);
    quat_t q;
    start <= 1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {r.m[0], r.m[1], r.m[2], r.m[3], r.m[4], r.m[5], r.m[6], r.m[7], r.m[8]};
    do @(posedge clk); while (busy);
    q = matrix_to_quat(r.m);
    if (r.known && q != r.q) begin
      $error("table row disagrees with predictor: w %0d/%0d", r.q.w, q.w);
      errors++;
    end
    pending_quats.push_back(r.known ? r.q : q);
  endtask

  task automatic idle_burst(bit allow);
    int n;
    if (allow && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    quat_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_quats.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_quats.pop_front();
        if (qw !== e.w) begin $error("qw exp %0d got %0d", e.w, qw); errors++; end
        if (qx !== e.x) begin $error("qx exp %0d got %0d", e.x, qx); errors++; end
        if (qy !== e.y) begin $error("qy exp %0d got %0d", e.y, qy); errors++; end
        if (qz !== e.z) begin $error("qz exp %0d got %0d", e.z, qz); errors++; end
        if (branch !== e.br) begin
          $error("branch exp %0d got %0d", e.br, branch); errors++;
        end
        if (invalid !== e.inv) begin
          $error("invalid exp %0d got %0d", e.inv, invalid); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion_tb: FAIL");
      $finish;
    end
  end

  initial begin
    build_table();
    repeat (6) @(posedge clk);
    rst <= 0;
    foreach (stim_table[t]) begin
      send_request(stim_table[t]);
      idle_burst(1);
    end
    for (int n = 0; n < N_RAND; n++) begin
      send_request(rand_row());
      idle_burst(n < N_RAND - 80);
    end
    start <= 0;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("rotation_matrix_to_quaternion_tb: PASS");
    else $display("rotation_matrix_to_quaternion_tb: FAIL");
    $finish;
  end

endmodule
